// ===== hw/rtl/gcm_pkg.sv =====
// gcm_pkg: shared constants and types for the grid cavity marker.
// No dependencies; used by grid_cavity_marker and grid_cavity_marker_test.
`timescale 1ns / 1ps

package gcm_pkg;

  localparam int MAX_SIDE = 32;
  localparam int CELL_W   = 8;
  localparam int SIZE_W   = 6;
  localparam int CNT_W    = $clog2(MAX_SIDE);
  localparam int N_W      = $clog2(MAX_SIDE + 1);
  localparam int EXT_W    = ((N_W > SIZE_W) ? N_W : SIZE_W) + 1;

  localparam logic [CELL_W-1:0] CAVITY_MARK     = 8'd88;
  localparam logic [SIZE_W-1:0] GRID_SIZE_RESET = 6'd32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FL_READ,
    ST_FL_OUT
  } state_t;

endpackage

// ===== hw/rtl/gcm_ram.sv =====
// gcm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/grid_cavity_marker.sv =====
// grid_cavity_marker: marks four-neighbour local maxima of a square grid with 'X'.
// Depends on gcm_pkg and gcm_ram (two line buffers).
// Each input word is handled in order: read centre/up, read right, evaluate and write back.
// Its result enters the output register at the end of the evaluate step.
// The final cell of a frame adds a flush that reads and emits each cell of the last row in turn.
// Output waits stall the evaluate and flush steps. Reset (synchronous) clears the
// counters and the left register and sets grid_size to 32; line buffers are not cleared.
`timescale 1ns / 1ps

module grid_cavity_marker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gcm_pkg::SIZE_W-1:0]  cfg_data,       // grid_size
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // cell_value
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,   // out_cell
  output logic                        m_axis_tuser,   // row_end
  output logic                        m_axis_tlast    // last_of_run
);

  localparam int CNT_W = gcm_pkg::CNT_W;
  localparam int EXT_W = gcm_pkg::EXT_W;
  localparam int CW    = gcm_pkg::CELL_W;

  gcm_pkg::state_t state, state_next;

  logic [gcm_pkg::SIZE_W-1:0] grid_size;
  logic [CNT_W-1:0]           row_count, column_count;
  logic [CNT_W-1:0]           r_cur, c_cur, flush_idx;
  logic [CW-1:0]              v_cur, center, up, left_cell;

  logic [EXT_W-1:0] n_eff, gs_ext, n_m1;
  logic             wrap;
  logic [CNT_W-1:0] r_eff, c_eff;

  logic             accept, out_free, has_out, go, final_cell, flush_last, cavity;
  logic             prev_rd_en, older_rd_en, buf_wr, emit;
  logic [CNT_W-1:0] prev_rd_addr;
  logic [CW-1:0]    prev_rd_data, older_rd_data, emit_data, right;
  logic             emit_row_end, emit_last;

  assign gs_ext = EXT_W'(grid_size);
  always_comb begin
    if (gs_ext == '0) begin
      n_eff = EXT_W'(1);
    end else if (gs_ext > EXT_W'(gcm_pkg::MAX_SIDE)) begin
      n_eff = EXT_W'(gcm_pkg::MAX_SIDE);
    end else begin
      n_eff = gs_ext;
    end
  end
  assign n_m1 = n_eff - EXT_W'(1);

  assign wrap  = (EXT_W'(row_count) >= n_eff) || (EXT_W'(column_count) >= n_eff);
  assign r_eff = wrap ? '0 : row_count;
  assign c_eff = wrap ? '0 : column_count;

  assign cfg_ready     = 1'b1;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == gcm_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign has_out    = (r_cur != '0);
  assign go         = !has_out || out_free;
  assign final_cell = (EXT_W'(r_cur) == n_m1) && (EXT_W'(c_cur) == n_m1);
  assign flush_last = (EXT_W'(flush_idx) == n_m1);
  assign right      = prev_rd_data;

  assign cavity = (EXT_W'(r_cur) >= EXT_W'(2)) && (EXT_W'(r_cur) + EXT_W'(1) <= n_eff) &&
                  (c_cur != '0) && (EXT_W'(c_cur) + EXT_W'(2) <= n_eff) &&
                  (center > up) && (center > v_cur) && (center > left_cell) &&
                  (center > right);

  always_comb begin
    state_next = state;
    unique case (state)
      gcm_pkg::ST_IDLE:    if (accept) state_next = gcm_pkg::ST_READ;
      gcm_pkg::ST_READ:    state_next = gcm_pkg::ST_EVAL;
      gcm_pkg::ST_EVAL: begin
        if (go) state_next = final_cell ? gcm_pkg::ST_FL_READ : gcm_pkg::ST_IDLE;
      end
      gcm_pkg::ST_FL_READ: state_next = gcm_pkg::ST_FL_OUT;
      gcm_pkg::ST_FL_OUT: begin
        if (out_free) state_next = flush_last ? gcm_pkg::ST_IDLE : gcm_pkg::ST_FL_READ;
      end
      default:             state_next = gcm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    prev_rd_en   = 1'b0;
    older_rd_en  = 1'b0;
    prev_rd_addr = c_eff;
    buf_wr       = 1'b0;
    emit         = 1'b0;
    emit_data    = prev_rd_data;
    emit_row_end = 1'b0;
    emit_last    = 1'b0;
    unique case (state)
      gcm_pkg::ST_IDLE: begin
        prev_rd_en   = accept;
        older_rd_en  = accept;
        prev_rd_addr = c_eff;
      end
      gcm_pkg::ST_READ: begin
        prev_rd_en   = 1'b1;
        prev_rd_addr = c_cur + CNT_W'(1);
      end
      gcm_pkg::ST_EVAL: begin
        buf_wr       = go;
        emit         = go && has_out;
        emit_data    = cavity ? gcm_pkg::CAVITY_MARK : center;
        emit_row_end = (EXT_W'(c_cur) == n_m1);
        emit_last    = !final_cell;
      end
      gcm_pkg::ST_FL_READ: begin
        prev_rd_en   = 1'b1;
        prev_rd_addr = flush_idx;
      end
      gcm_pkg::ST_FL_OUT: begin
        emit         = out_free;
        emit_data    = prev_rd_data;
        emit_row_end = flush_last;
        emit_last    = flush_last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= gcm_pkg::ST_IDLE;
      grid_size     <= gcm_pkg::GRID_SIZE_RESET;
      row_count     <= '0;
      column_count  <= '0;
      left_cell     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        grid_size    <= cfg_data;
        row_count    <= '0;
        column_count <= '0;
      end else if (state == gcm_pkg::ST_EVAL && go) begin
        left_cell <= center;
        if (final_cell) begin
          row_count    <= '0;
          column_count <= '0;
        end else if (EXT_W'(c_cur) == n_m1) begin
          row_count    <= r_cur + CNT_W'(1);
          column_count <= '0;
        end else begin
          row_count    <= r_cur;
          column_count <= c_cur + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_cur <= r_eff;
      c_cur <= c_eff;
      v_cur <= s_axis_tdata;
    end
    if (state == gcm_pkg::ST_READ) begin
      center <= prev_rd_data;
      up     <= older_rd_data;
    end
    if (state == gcm_pkg::ST_EVAL) begin
      flush_idx <= '0;
    end else if (state == gcm_pkg::ST_FL_OUT && out_free) begin
      flush_idx <= flush_idx + CNT_W'(1);
    end
    if (emit) begin
      m_axis_tdata <= emit_data;
      m_axis_tuser <= emit_row_end;
      m_axis_tlast <= emit_last;
    end
  end

  gcm_ram #(
    .WIDTH (CW),
    .DEPTH (gcm_pkg::MAX_SIDE)
  ) u_prev_row (
    .clk     (clk),
    .wr_en   (buf_wr),
    .wr_addr (c_cur),
    .wr_data (v_cur),
    .rd_en   (prev_rd_en),
    .rd_addr (prev_rd_addr),
    .rd_data (prev_rd_data)
  );

  gcm_ram #(
    .WIDTH (CW),
    .DEPTH (gcm_pkg::MAX_SIDE)
  ) u_older_row (
    .clk     (clk),
    .wr_en   (buf_wr),
    .wr_addr (c_cur),
    .wr_data (center),
    .rd_en   (older_rd_en),
    .rd_addr (c_eff),
    .rd_data (older_rd_data)
  );

endmodule

// ===== tb/grid_cavity_marker_test.sv =====
// grid_cavity_marker_test: self-checking bench for the grid cavity marker.
// Depends on gcm_pkg and the grid_cavity_marker RTL; drives cell words, predicts
// the marked cells with row-end and last-of-run flags, and checks every output word.
`timescale 1ns / 1ps

module grid_cavity_marker_test;

  typedef struct {
    logic [gcm_pkg::CELL_W-1:0] value;
    logic                       row_end;
    logic                       run_end;
  } marked_word_t;

  typedef enum int {FILL_UNIFORM, FILL_LOW, FILL_EXTREME, FILL_CHECKER} fill_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [gcm_pkg::SIZE_W-1:0] cfg_data = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [7:0]                 s_axis_tdata = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [7:0]                 m_axis_tdata;
  logic                       m_axis_tuser;
  logic                       m_axis_tlast;

  // predictor state
  logic [gcm_pkg::CELL_W-1:0] older_line [gcm_pkg::MAX_SIDE];
  logic [gcm_pkg::CELL_W-1:0] prev_line [gcm_pkg::MAX_SIDE];
  logic [gcm_pkg::CELL_W-1:0] left_val;
  int unsigned                row_pos;
  int unsigned                col_pos;
  logic [gcm_pkg::SIZE_W-1:0] side_reg;

  marked_word_t marked_q[$];
  int           mismatches = 0;
  bit           quiet = 1'b0;
  int           ready_hold = 0;

  grid_cavity_marker i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned clamp_side(input logic [gcm_pkg::SIZE_W-1:0] sz);
    int unsigned n;
    n = 32'(sz);
    if (n < 1) n = 1;
    if (n > gcm_pkg::MAX_SIDE) n = gcm_pkg::MAX_SIDE;
    return n;
  endfunction

  function automatic logic [7:0] pick_cell(input fill_t mode, input int unsigned idx,
                                           input int unsigned n);
    int unsigned rr;
    int unsigned cc;
    rr = (idx / n) % n;
    cc = idx % n;
    case (mode)
      FILL_LOW:     return 8'($urandom_range(0, 3));
      FILL_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return 8'h00;
          1: return 8'h01;
          2: return 8'hFE;
          default: return 8'hFF;
        endcase
      end
      FILL_CHECKER: begin
        if ((rr + cc) % 2 == 0) return 8'($urandom_range(128, 255));
        return 8'($urandom_range(0, 127));
      end
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void push_marked(input logic [7:0] v, input bit re, input bit last_flag);
    marked_word_t w;
    w.value   = v;
    w.row_end = re;
    w.run_end = last_flag;
    marked_q.push_back(w);
  endfunction

  // four-neighbour local maximum, output one row behind the input
  function automatic void predict_cavity(input logic [7:0] v);
    int unsigned n;
    int unsigned r;
    int unsigned c;
    bit          flush;
    logic [7:0]  centre;
    logic [7:0]  res;
    n = clamp_side(side_reg);
    if (row_pos >= n || col_pos >= n) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    flush = (r == n - 1) && (c == n - 1);
    if (r >= 1) begin
      centre = prev_line[c];
      res = centre;
      if (r >= 2 && r + 1 <= n && c >= 1 && c + 2 <= n) begin
        if (centre > older_line[c] && centre > v && centre > left_val &&
            centre > prev_line[c + 1])
          res = gcm_pkg::CAVITY_MARK;
      end
      push_marked(res, c == n - 1, !flush);
    end
    left_val      = prev_line[c];
    older_line[c] = prev_line[c];
    prev_line[c]  = v;
    if (flush) begin
      for (int unsigned j = 0; j < n; j++)
        push_marked(prev_line[j], j == n - 1, j == n - 1);
      row_pos = 0;
      col_pos = 0;
    end else if (c == n - 1) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  task automatic send_cell(input logic [7:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk); while (!s_axis_tready);
    predict_cavity(v);
  endtask

  // all expected words out, then room for a cell that yields nothing
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (marked_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_size(input logic [gcm_pkg::SIZE_W-1:0] sz);
    cfg_valid <= 1'b1;
    cfg_data  <= sz;
    do @(posedge clk); while (!cfg_ready);
    side_reg = sz;
    row_pos  = 0;
    col_pos  = 0;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input logic [7:0] cells[$]);
    foreach (cells[k]) send_cell(cells[k]);
    settle();
  endtask

  task automatic send_fill(input fill_t mode, input int unsigned count, input int unsigned n);
    for (int unsigned k = 0; k < count; k++) send_cell(pick_cell(mode, k, n));
    settle();
  endtask

  // default size after reset, partial frame (the next test restarts it by a write)
  task automatic test_reset_size();
    send_fill(FILL_CHECKER, 40, gcm_pkg::MAX_SIDE);
  endtask

  task automatic test_one_cell();
    write_size(6'd1);
    send_frame('{8'h00, 8'hFF});
    write_size(6'd0);
    send_frame('{8'h5A});
  endtask

  task automatic test_small_grids();
    write_size(6'd3);
    send_frame('{8'd10, 8'd20, 8'd30, 8'd40, 8'd200, 8'd50, 8'd60, 8'd70, 8'd80});
    // centre equal to the cell above: no mark
    send_frame('{8'd10, 8'd200, 8'd30, 8'd40, 8'd200, 8'd50, 8'd60, 8'd70, 8'd80});
    write_size(6'd2);
    send_frame('{8'hFF, 8'h00, 8'h01, 8'hFE});
  endtask

  // oversize and full size, partial frames
  task automatic test_full_size();
    write_size(6'd63);
    send_fill(FILL_CHECKER, 2 * gcm_pkg::MAX_SIDE + 5, gcm_pkg::MAX_SIDE);
    write_size(6'd32);
    send_fill(FILL_UNIFORM, gcm_pkg::MAX_SIDE + 3, gcm_pkg::MAX_SIDE);
  endtask

  task automatic test_random_frames();
    int          sent;
    int          sel;
    logic [5:0]  sz;
    int unsigned n;
    int unsigned count;
    fill_t       mode;
    sent = 0;
    while (sent < 200) begin
      sel = $urandom_range(0, 99);
      if (sel < 5) sz = 6'd0;
      else if (sel < 75) sz = 6'($urandom_range(1, 8));
      else if (sel < 92) sz = 6'($urandom_range(9, 16));
      else if (sel < 96) sz = 6'd32;
      else sz = 6'($urandom_range(33, 63));
      n = clamp_side(sz);
      quiet = ($urandom_range(0, 5) == 0);
      mode = fill_t'($urandom_range(0, 3));
      if (n > 16) count = $urandom_range(n, 3 * n);
      else if ($urandom_range(0, 4) == 0) count = $urandom_range(1, n * n);
      else count = n * n * $urandom_range(1, 2);
      if (count > 32'(200 - sent)) count = 32'(200 - sent);
      write_size(sz);
      send_fill(mode, count, n);
      sent += int'(count);
    end
    quiet = 1'b0;
  endtask

  // output-side back-pressure
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      m_axis_tready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 99) < 30) ready_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    marked_word_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (marked_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: %h row_end %b last %b", m_axis_tdata, m_axis_tuser,
                   m_axis_tlast);
      end else begin
        w = marked_q.pop_front();
        if (m_axis_tdata !== w.value || m_axis_tuser !== w.row_end ||
            m_axis_tlast !== w.run_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h/%b/%b got %h/%b/%b", w.value, w.row_end,
                     w.run_end, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
      end
    end
  end

  initial begin
    for (int k = 0; k < gcm_pkg::MAX_SIDE; k++) begin
      older_line[k] = '0;
      prev_line[k]  = '0;
    end
    left_val = '0;
    row_pos  = 0;
    col_pos  = 0;
    side_reg = gcm_pkg::GRID_SIZE_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_size();
    test_one_cell();
    test_small_grids();
    test_full_size();
    test_random_frames();
    settle();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && marked_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
